// File: src/ipv4rfm_pkg.sv
// Shared types, constants and helpers for the IPv4 range first-match table.
// No dependencies; used by ipv4_range_first_match_table_unit.
package ipv4rfm_pkg;

  localparam int ENTRIES   = 1024;
  localparam int ADDR_W    = 32;
  localparam int PLEN_W    = 6;
  localparam int REGION_W  = 31;
  localparam int OUT_IDX_W = 10;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_HIT      = 2'd2,
    STAT_MISS     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic                operation;
    logic [ADDR_W-1:0]   address;
    logic [PLEN_W-1:0]   prefix_len;
    logic [REGION_W-1:0] region_id;
  } in_t;

  typedef struct packed {
    status_t              status;
    logic [OUT_IDX_W-1:0] entry_index;
    logic [REGION_W-1:0]  found_region;
  } out_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   rng_start;
    logic [ADDR_W-1:0]   rng_end;
    logic [REGION_W-1:0] rng_region;
  } entry_t;

  // Prefix length 0 gives an all-ones host mask; anything above 32 acts as 32.
  function automatic logic [ADDR_W-1:0] host_mask(input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] m;
    if (plen == '0) begin
      m = '1;
    end else if (plen >= PLEN_W'(ADDR_W)) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} >> plen;
    end
    return m;
  endfunction

  function automatic logic [OUT_IDX_W-1:0] to_out_index(input logic [IDX_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[OUT_IDX_W-1:0];
  endfunction

endpackage

// File: src/ipv4_range_first_match_table_unit.sv
// IPv4 range table with insert and oldest-first lookup, one result per beat.
// Depends on ipv4rfm_pkg for types, constants and the host mask helper.

// Items are taken when start is high and busy is low; each item gives exactly
// one result, shown for a single cycle with out_strobe, which the receiver must
// take as it comes. An insert is done in ST_INSERT, which writes the entry
// unless the table is full and then returns to idle. A lookup walks the entry
// memory from the oldest entry, one entry per cycle through its single
// registered read port and one range compare, until the first hit or the
// last filled entry. Entries are never cleared; the table only grows until
// reset. No clearing pass is needed after reset.
module ipv4_range_first_match_table_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ipv4rfm_pkg::in_t  in_item,
  output logic              out_strobe,
  output ipv4rfm_pkg::out_t out_item
);

  ipv4rfm_pkg::state_t state_r, state_nxt;
  ipv4rfm_pkg::in_t    item_r;

  logic [ipv4rfm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ipv4rfm_pkg::CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic                          pend_r, pend_nxt;
  logic [ipv4rfm_pkg::IDX_W-1:0] pend_idx_r;

  ipv4rfm_pkg::entry_t entry_mem [ipv4rfm_pkg::ENTRIES];
  ipv4rfm_pkg::entry_t rd_data_r;
  ipv4rfm_pkg::entry_t wr_data;
  logic                mem_we;
  logic                rd_en;

  logic              out_strobe_r;
  ipv4rfm_pkg::out_t out_item_r;
  logic              emit;
  ipv4rfm_pkg::out_t emit_item;

  logic accept;
  logic full;
  logic more;
  logic hit;

  assign busy       = (state_r != ipv4rfm_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  assign full = (cnt_r >= ipv4rfm_pkg::CNT_W'(ipv4rfm_pkg::ENTRIES));
  assign more = (rd_ptr_r < cnt_r);
  assign hit  = pend_r
             && (item_r.address >= rd_data_r.rng_start)
             && (item_r.address <= rd_data_r.rng_end);

  assign wr_data.rng_start  = item_r.address;
  assign wr_data.rng_end    = item_r.address | ipv4rfm_pkg::host_mask(item_r.prefix_len);
  assign wr_data.rng_region = item_r.region_id;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ipv4rfm_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_item.operation == ipv4rfm_pkg::OP_INSERT) ?
                      ipv4rfm_pkg::ST_INSERT : ipv4rfm_pkg::ST_WALK;
        end
      end
      ipv4rfm_pkg::ST_INSERT: begin
        state_nxt = ipv4rfm_pkg::ST_IDLE;
      end
      ipv4rfm_pkg::ST_WALK: begin
        if (hit || !more) begin
          state_nxt = ipv4rfm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ipv4rfm_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cnt_nxt    = cnt_r;
    rd_ptr_nxt = rd_ptr_r;
    pend_nxt   = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    emit       = 1'b0;
    emit_item  = '{status: ipv4rfm_pkg::STAT_MISS, entry_index: '0, found_region: '0};
    unique case (state_r)
      ipv4rfm_pkg::ST_IDLE: begin
        rd_ptr_nxt = '0;
      end
      ipv4rfm_pkg::ST_INSERT: begin
        emit = 1'b1;
        if (full) begin
          emit_item.status = ipv4rfm_pkg::STAT_FULL;
        end else begin
          mem_we                = 1'b1;
          cnt_nxt               = cnt_r + 1'b1;
          emit_item.status      = ipv4rfm_pkg::STAT_INSERTED;
          emit_item.entry_index =
            ipv4rfm_pkg::to_out_index(cnt_r[ipv4rfm_pkg::IDX_W-1:0]);
        end
      end
      ipv4rfm_pkg::ST_WALK: begin
        if (hit) begin
          emit                   = 1'b1;
          emit_item.status       = ipv4rfm_pkg::STAT_HIT;
          emit_item.entry_index  = ipv4rfm_pkg::to_out_index(pend_idx_r);
          emit_item.found_region = rd_data_r.rng_region;
        end else if (more) begin
          rd_en      = 1'b1;
          pend_nxt   = 1'b1;
          rd_ptr_nxt = rd_ptr_r + 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ipv4rfm_pkg::ST_IDLE;
      cnt_r        <= '0;
      rd_ptr_r     <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (rd_en) begin
      pend_idx_r <= rd_ptr_r[ipv4rfm_pkg::IDX_W-1:0];
    end
    if (emit) begin
      out_item_r <= emit_item;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[cnt_r[ipv4rfm_pkg::IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= entry_mem[rd_ptr_r[ipv4rfm_pkg::IDX_W-1:0]];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ipv4rfm_pkg::CNT_W'(ipv4rfm_pkg::ENTRIES))
    else $error("entry count above table depth");

  a_walk_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ipv4rfm_pkg::ST_WALK) |-> (rd_ptr_r <= cnt_r))
    else $error("walk pointer past filled entries");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r != ipv4rfm_pkg::ST_IDLE))
    else $error("result strobe without work in progress");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == ipv4rfm_pkg::STAT_INSERTED)
      |-> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert result without count advance");

endmodule
